### rtl/core/swd_pkg.sv
// shared types and constants of the single-wire sensor pulse decoder
`default_nettype none

package swd_pkg;

  localparam int unsigned NumPhasesDef  = 83;
  localparam int unsigned FirstBitPhase = 4;
  localparam int unsigned MaxBits       = 40;
  localparam int unsigned NumBytes      = 5;
  localparam int unsigned QueueDepth    = 2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] StartLowRst  = 16'd18000;
  localparam logic [7:0]  ThresholdRst = 8'd30;
  localparam logic [7:0]  TimeoutRst   = 8'd200;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartLow  = 2'd0,
    CfgThreshold = 2'd1,
    CfgTimeout   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic line_level;
    logic start_read;
  } in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       timed_out;
    logic [7:0] humidity_int;
    logic [7:0] humidity_frac;
    logic [7:0] temp_int;
    logic [7:0] temp_frac;
    logic [7:0] check_byte;
    logic [5:0] bits_received;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/swd_fifo.sv
// two-entry word queue used on both sides of the decoder
`default_nettype none

module swd_fifo #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output T     rdata_o,
  output logic empty_o
);
  import swd_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  T              mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/swd_core.sv
// phase sequencer: start pulse, phase width measurement and bit capture
`default_nettype none

module swd_core #(
  parameter int unsigned NumPhases = swd_pkg::NumPhasesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [swd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [swd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          step_i,
  input  swd_pkg::in_t                  item_i,
  output swd_pkg::res_t                 res_o
);
  import swd_pkg::*;

  typedef enum logic [1:0] {
    ModeIdle    = 2'd0,
    ModeStart   = 2'd1,
    ModeMeasure = 2'd2
  } mode_e;

  localparam logic [6:0] PhaseLimit = 7'(NumPhases);
  localparam logic [6:0] FirstBit   = 7'(FirstBitPhase);
  localparam logic [5:0] BitLimit   = 6'(MaxBits);

  logic [15:0] start_low_q;
  logic [7:0]  threshold_q, timeout_q;

  mode_e       mode_q, mode_d;
  logic [15:0] start_cnt_q, start_cnt_d;
  logic [6:0]  edge_q, edge_d;
  logic [7:0]  width_q, width_d;
  logic        last_q, last_d;
  logic [7:0]  bytes_q [NumBytes];
  logic [7:0]  bytes_d [NumBytes];
  logic [5:0]  bits_q, bits_d;
  logic        drive, done, tmo, bit_val;

  always_comb begin
    mode_d      = mode_q;
    start_cnt_d = start_cnt_q;
    edge_d      = edge_q;
    width_d     = width_q;
    last_d      = last_q;
    bytes_d     = bytes_q;
    bits_d      = bits_q;
    drive       = 1'b0;
    done        = 1'b0;
    tmo         = 1'b0;
    bit_val     = (width_q > threshold_q);

    case (mode_q)
      ModeStart, ModeMeasure: ;
      default: begin
        mode_d = ModeIdle;
        if (item_i.start_read) begin
          for (int k = 0; k < NumBytes; k++) begin
            bytes_d[k] = '0;
          end
          bits_d      = '0;
          start_cnt_d = '0;
          mode_d      = ModeStart;
        end
      end
    endcase

    if (mode_d == ModeStart) begin
      drive       = 1'b1;
      start_cnt_d = start_cnt_d + 1'b1;
      if (start_cnt_d >= start_low_q || start_cnt_d == '0) begin
        mode_d  = ModeMeasure;
        edge_d  = '0;
        width_d = '0;
        last_d  = 1'b1;
      end
    end else if (mode_d == ModeMeasure) begin
      if (item_i.line_level == last_q) begin
        width_d = width_q + 1'b1;
        if (width_d == timeout_q) begin
          mode_d = ModeIdle;
          done   = 1'b1;
          tmo    = 1'b1;
        end
      end else begin
        last_d = item_i.line_level;
        if (edge_q >= FirstBit && !edge_q[0] && bits_q < BitLimit) begin
          for (int k = 0; k < NumBytes; k++) begin
            if (bits_q[5:3] == 3'(k)) begin
              bytes_d[k] = {bytes_q[k][6:0], bit_val};
            end
          end
          bits_d = bits_q + 1'b1;
        end
        edge_d  = edge_q + 1'b1;
        width_d = '0;
        if (edge_d >= PhaseLimit) begin
          mode_d = ModeIdle;
          done   = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_o.drive_low     = drive;
    res_o.busy_res      = (mode_d == ModeStart) || (mode_d == ModeMeasure);
    res_o.done_res      = done;
    res_o.timed_out     = tmo;
    res_o.humidity_int  = bytes_d[0];
    res_o.humidity_frac = bytes_d[1];
    res_o.temp_int      = bytes_d[2];
    res_o.temp_frac     = bytes_d[3];
    res_o.check_byte    = bytes_d[4];
    res_o.bits_received = bits_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_low_q <= StartLowRst;
      threshold_q <= ThresholdRst;
      timeout_q   <= TimeoutRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgStartLow:  start_low_q <= cfg_data_i;
        CfgThreshold: threshold_q <= cfg_data_i[7:0];
        CfgTimeout:   timeout_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeIdle;
      start_cnt_q <= '0;
      edge_q      <= '0;
      width_q     <= '0;
      last_q      <= 1'b1;
      bits_q      <= '0;
      for (int k = 0; k < NumBytes; k++) begin
        bytes_q[k] <= '0;
      end
    end else if (step_i) begin
      mode_q      <= mode_d;
      start_cnt_q <= start_cnt_d;
      edge_q      <= edge_d;
      width_q     <= width_d;
      last_q      <= last_d;
      bits_q      <= bits_d;
      bytes_q     <= bytes_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/single_wire_sensor_pulse_decoder.sv
// top level of the single-wire sensor pulse decoder
// usage:
//   each input word carries one sampled line level and a start request;
//   it is taken on a clock edge with push high and full low
//   every input word produces exactly one result word, in order
//   results wait in a two-word queue; the oldest is on res_o while empty
//   is low and leaves on an edge with pop high
//   a pushed word goes through the input queue and a sequencer step into the result queue before it is on res_o
//   throughput is one word per cycle while the result queue has room, set by the
//   single-step sequencer between the input queue and the result queue
//   when pop stays low the result queue fills, the sequencer holds, then
//   the input queue fills and full goes high; nothing is lost
//   configuration writes use cfg_valid_i / cfg_ready_o (always ready),
//   index 0 start low ticks, 1 bit threshold, 2 timeout ticks; write only
//   while no word is in flight
//   reset empties both queues, idles the sequencer, clears the bytes and
//   restores the default register values
`default_nettype none

module single_wire_sensor_pulse_decoder #(
  parameter int unsigned NumPhases = swd_pkg::NumPhasesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  swd_pkg::in_t                  in_i,
  output logic                          full,
  input  logic                          pop,
  output swd_pkg::res_t                 res_o,
  output logic                          empty,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [swd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [swd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import swd_pkg::*;

  in_t  item;
  res_t res_word;
  logic item_empty, res_full, step;

  assign cfg_ready_o = 1'b1;
  assign step        = !item_empty && !res_full;

  swd_fifo #(.T(in_t)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (in_i),
    .full_o  (full),
    .pop_i   (step),
    .rdata_o (item),
    .empty_o (item_empty)
  );

  swd_core #(.NumPhases(NumPhases)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .item_i      (item),
    .res_o       (res_word)
  );

  swd_fifo #(.T(res_t)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .wdata_i (res_word),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_o),
    .empty_o (empty)
  );

`ifndef NO_ASSERTIONS
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(res_o.done_res && res_o.busy_res))
    else $error("finished read still marked busy");

  a_timeout_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.timed_out) |-> res_o.done_res)
    else $error("timeout flag without done");

  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.drive_low) |-> (res_o.busy_res && !res_o.done_res))
    else $error("line driven outside start pulse");

  a_bit_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (res_o.bits_received <= 6'(MaxBits)))
    else $error("bit count above limit");
`endif

endmodule

`default_nettype wire
